// ===== rtl/i2cts_pkg.sv =====
// Shared types and constants for the I2C master transaction sequencer.
package i2cts_pkg;

    // Transmit store geometry
    localparam int TX_DEPTH = 256;
    localparam int TX_AW    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam logic [8:0] TX_DEPTH_W = 9'(TX_DEPTH);

    localparam logic [3:0] RETRY_LIMIT_RST = 4'd3;
    localparam logic [7:0] RETRY_COUNT_MAX = 8'hFF;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_EVENT = 2'd1,
        OP_ERROR = 2'd2,
        OP_LOAD  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_ADDR      = 3'd1,
        ACT_DATA      = 3'd2,
        ACT_STOP_ADDR = 3'd3,
        ACT_STOP      = 3'd4
    } action_t;

    typedef struct packed {
        op_t        op;
        logic [6:0] slave_addr;
        logic [7:0] tx_count;
        logic [7:0] rx_count;
        logic       nack;
        logic       arb_lost;
        logic [7:0] load_index;
        logic [7:0] load_data;
    } item_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] bus_byte;
        logic       force_idle;
        logic       done_res;
        logic       failed;
    } result_t;

    typedef struct packed {
        logic             en;
        logic [TX_AW-1:0] addr;
        logic [7:0]       data;
    } store_wr_t;

endpackage

// ===== rtl/i2cts_store.sv =====
// Transmit byte store with write-first registered read port.
module i2cts_store (
    input  logic                     clk,
    input  i2cts_pkg::store_wr_t     wr,
    input  logic [i2cts_pkg::TX_AW-1:0] rd_addr,
    output logic [7:0]               rd_data
);
    import i2cts_pkg::*;

    logic [7:0] mem [TX_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Same-cycle write to the prefetched address is forwarded
    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.addr == rd_addr))
        begin
            rd_data_reg <= wr.data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/i2cts_ctrl.sv =====
// Transaction state registers and per-event decision logic.
module i2cts_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [3:0]                  cfg_wr_data,
    input  logic                        step,
    input  i2cts_pkg::item_t            item,
    input  logic [7:0]                  rd_data,
    output i2cts_pkg::result_t          result,
    output i2cts_pkg::store_wr_t        store_wr,
    output logic [i2cts_pkg::TX_AW-1:0] rd_addr
);
    import i2cts_pkg::*;

    logic [3:0] retry_limit_reg;
    logic [6:0] target_addr_reg, target_addr_next;
    logic [7:0] write_len_reg, write_len_next;
    logic [7:0] read_len_reg, read_len_next;
    logic [7:0] byte_pos_reg, byte_pos_next;
    logic [7:0] retry_count_reg, retry_count_next;

    logic       retry_ok;
    logic [7:0] retry_count_inc;
    logic [7:0] addr_byte;
    logic       pos_in_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg <= RETRY_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            retry_limit_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_addr_reg <= '0;
            write_len_reg   <= '0;
            read_len_reg    <= '0;
            byte_pos_reg    <= '0;
            retry_count_reg <= '0;
        end
        else
        begin
            target_addr_reg <= target_addr_next;
            write_len_reg   <= write_len_next;
            read_len_reg    <= read_len_next;
            byte_pos_reg    <= byte_pos_next;
            retry_count_reg <= retry_count_next;
        end
    end

    // Limit check uses the count before it is bumped
    assign retry_ok        = retry_count_reg < {4'b0, retry_limit_reg};
    assign retry_count_inc = (retry_count_reg != RETRY_COUNT_MAX) ?
                             retry_count_reg + 8'd1 : retry_count_reg;
    assign addr_byte       = {target_addr_reg, (write_len_reg == 8'd0)};
    assign pos_in_range    = {1'b0, byte_pos_reg} < TX_DEPTH_W;

    always_comb
    begin
        target_addr_next = target_addr_reg;
        write_len_next   = write_len_reg;
        read_len_next    = read_len_reg;
        byte_pos_next    = byte_pos_reg;
        retry_count_next = retry_count_reg;
        result           = '{action: ACT_NONE, bus_byte: 8'd0, force_idle: 1'b0,
                             done_res: 1'b0, failed: 1'b0};
        store_wr         = '{en: 1'b0, addr: item.load_index[TX_AW-1:0],
                             data: item.load_data};

        if (step)
        begin
            unique case (item.op)
                OP_START:
                begin
                    target_addr_next = item.slave_addr;
                    write_len_next   = item.tx_count;
                    read_len_next    = item.rx_count;
                    byte_pos_next    = 8'd0;
                    retry_count_next = 8'd0;
                    result.action    = ACT_ADDR;
                    result.bus_byte  = {item.slave_addr, (item.tx_count == 8'd0)};
                end
                OP_EVENT:
                begin
                    if (item.nack)
                    begin
                        result.force_idle = 1'b1;
                        retry_count_next  = retry_count_inc;
                        if (retry_ok)
                        begin
                            byte_pos_next   = 8'd0;
                            result.action   = ACT_ADDR;
                            result.bus_byte = addr_byte;
                        end
                        else
                        begin
                            result.action   = ACT_STOP;
                            result.done_res = 1'b1;
                            result.failed   = 1'b1;
                        end
                    end
                    else if (byte_pos_reg < write_len_reg)
                    begin
                        result.action   = ACT_DATA;
                        result.bus_byte = pos_in_range ? rd_data : 8'd0;
                        byte_pos_next   = byte_pos_reg + 8'd1;
                    end
                    else
                    begin
                        result.force_idle = 1'b1;
                        if (read_len_reg != 8'd0)
                        begin
                            // repeated start, direction bit forced to read
                            byte_pos_next   = 8'd0;
                            write_len_next  = 8'd0;
                            result.action   = ACT_STOP_ADDR;
                            result.bus_byte = {target_addr_reg, 1'b1};
                        end
                        else
                        begin
                            result.action   = ACT_STOP;
                            result.done_res = 1'b1;
                        end
                    end
                end
                OP_ERROR:
                begin
                    retry_count_next = retry_count_inc;
                    if (retry_ok && item.arb_lost)
                    begin
                        byte_pos_next   = 8'd0;
                        result.action   = ACT_ADDR;
                        result.bus_byte = addr_byte;
                    end
                end
                OP_LOAD:
                begin
                    store_wr.en = {1'b0, item.load_index} < TX_DEPTH_W;
                end
                default:
                begin
                    result.action = ACT_NONE;
                end
            endcase
        end
    end

    // Prefetch the byte at the next position so it is ready for the next event
    assign rd_addr = byte_pos_next[TX_AW-1:0];

endmodule

// ===== rtl/i2c_master_txn_sequencer_unit.sv =====
// Top level of the I2C master write-then-read transaction sequencer.
//
// Usage:
//   Input stream (s_axis_*) carries one bus-side event per transaction:
//   start, master-on-bus, bus error, or load of a transmit byte (tuser op).
//   Output stream (m_axis_*) returns exactly one result per input
//   transaction: the bus action (tuser) with the byte to drive and the
//   idle / done / failed flags (tdata).
//   cfg_wr_en / cfg_wr_data write the 4-bit retry limit (reset value 3);
//   write it only while no transaction is in flight.
// Path: an accepted item is held in the input register, then its result
//   is captured in the result register, from which it can be taken.
//   Throughput: one transaction per cycle while m_axis_tready is high; the
//   data path is a few compares plus a read of the 256-byte transmit store,
//   whose registered read port is prefetched at the current byte position.
// Reset: rst_n (async, active low) empties both pipeline registers, clears
//   the address, lengths, position and retry count and restores the retry
//   limit. The transmit store is not cleared; load before sending.
// Stall: when m_axis_tready is low a valid result stays in place; the input
//   register can still take one transaction, then tready drops.
module i2c_master_txn_sequencer_unit (
    input  logic        clk,
    input  logic        rst_n,
    // retry limit register
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    // input events
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // slave_addr[6:0], tx_count[14:7], rx_count[22:15], nack[23], arb_lost[24],
    // load_index[32:25], load_data[40:33], zero[47:41]
    input  logic [47:0] s_axis_tdata,
    // op[1:0]
    input  logic [1:0]  s_axis_tuser,
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // bus_byte[7:0], force_idle[8], done_res[9], failed[10], zero[15:11]
    output logic [15:0] m_axis_tdata,
    // action[2:0]
    output logic [2:0]  m_axis_tuser
);
    import i2cts_pkg::*;

    logic      in_valid_reg;
    item_t     in_item_reg;
    logic      out_valid_reg;
    result_t   out_res_reg;
    logic      advance;

    result_t   step_res;
    store_wr_t store_wr;
    logic [TX_AW-1:0] rd_addr;
    logic [7:0] rd_data;

    // An item moves into the result register when that register is empty or being read
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg <= '{op:         op_t'(s_axis_tuser),
                             slave_addr: s_axis_tdata[6:0],
                             tx_count:   s_axis_tdata[14:7],
                             rx_count:   s_axis_tdata[22:15],
                             nack:       s_axis_tdata[23],
                             arb_lost:   s_axis_tdata[24],
                             load_index: s_axis_tdata[32:25],
                             load_data:  s_axis_tdata[40:33]};
        end
    end

    i2cts_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (advance),
        .item        (in_item_reg),
        .rd_data     (rd_data),
        .result      (step_res),
        .store_wr    (store_wr),
        .rd_addr     (rd_addr)
    );

    i2cts_store u_store (
        .clk     (clk),
        .wr      (store_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.action;
    assign m_axis_tdata  = {5'd0, out_res_reg.failed, out_res_reg.done_res,
                            out_res_reg.force_idle, out_res_reg.bus_byte};

    // Failure is only ever reported with a stop
    a_fail_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.failed |-> out_res_reg.done_res &&
        (out_res_reg.action == ACT_STOP))
        else $error("failed without done/stop");

    // Completion always forces the bus idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.done_res |-> out_res_reg.force_idle)
        else $error("done without force_idle");

    // Data bytes never come with idle or completion
    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_res_reg.action == ACT_DATA) |->
        !out_res_reg.force_idle && !out_res_reg.done_res)
        else $error("data action with idle/done");

    // A held input item stays held until it advances
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("input item lost while stalled");

    // Result register refills only from an advancing item
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg && !advance |=> !out_valid_reg)
        else $error("result appeared without an item");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the I2C master write-then-read transaction sequencer.
`timescale 1ns / 100ps

module tb_top;
    import i2cts_pkg::*;

    // A stretch this long with no transaction on either side means the block hung
    localparam int STALL_LIMIT   = 1000;
    // Two register stages plus margin, waited out before a retry limit write
    localparam int SETTLE_CYCLES = 4;
    localparam int TXN_TARGET    = 1950;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [3:0]  cfg_wr_data   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    // Set for a stretch of the run in which neither side ever idles
    logic        steady        = 1'b0;
    int          n_txns        = 0;
    int          errors        = 0;
    int          stall_cycles  = 0;

    // Results owed by the block, oldest first
    result_t     pending_results[$];

    // Predicted sequencer state; the retry limit mirrors the register
    logic [3:0]  lim_q         = RETRY_LIMIT_RST;
    logic [6:0]  tgt_q         = '0;
    logic [7:0]  wr_len_q      = '0;
    logic [7:0]  rd_len_q      = '0;
    logic [7:0]  pos_q         = '0;
    logic [7:0]  retries_q     = '0;
    logic [7:0]  tx_bytes[TX_DEPTH];
    bit          tx_written[TX_DEPTH];

    i2c_master_txn_sequencer_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Address byte on the bus: read bit set when nothing is left to write
    function automatic logic [7:0] address_byte();
        return {tgt_q, wr_len_q == 8'd0};
    endfunction

    // Every NACK or bus error is one attempt; the limit check sees the
    // count before it moves, and the count sticks at its maximum
    function automatic logic count_retry();
        logic ok;
        ok = ({1'b0, retries_q} < {5'd0, lim_q});
        if (retries_q != RETRY_COUNT_MAX)
            retries_q = retries_q + 8'd1;
        return ok;
    endfunction

    task automatic predict_bus_action(input item_t t, output result_t r);
        r = '0;
        r.action = ACT_NONE;
        case (t.op)
            OP_START:
            begin
                tgt_q     = t.slave_addr;
                wr_len_q  = t.tx_count;
                rd_len_q  = t.rx_count;
                pos_q     = '0;
                retries_q = '0;
                r.action   = ACT_ADDR;
                r.bus_byte = address_byte();
            end
            OP_EVENT:
            begin
                if (t.nack)
                begin
                    // NACK: retry the address, or give up and report failure
                    r.force_idle = 1'b1;
                    if (count_retry())
                    begin
                        pos_q      = '0;
                        r.action   = ACT_ADDR;
                        r.bus_byte = address_byte();
                    end
                    else
                    begin
                        r.action   = ACT_STOP;
                        r.done_res = 1'b1;
                        r.failed   = 1'b1;
                    end
                end
                else if (pos_q < wr_len_q)
                begin
                    r.action   = ACT_DATA;
                    r.bus_byte = tx_bytes[pos_q];
                    pos_q      = pos_q + 8'd1;
                end
                else
                begin
                    // write phase over: repeated start for the read, or finish
                    r.force_idle = 1'b1;
                    if (rd_len_q != 8'd0)
                    begin
                        pos_q      = '0;
                        wr_len_q   = '0;
                        r.action   = ACT_STOP_ADDR;
                        r.bus_byte = address_byte();
                    end
                    else
                    begin
                        r.action   = ACT_STOP;
                        r.done_res = 1'b1;
                    end
                end
            end
            OP_ERROR:
            begin
                // counted even without lost arbitration; only that re-addresses
                if (count_retry() && t.arb_lost)
                begin
                    pos_q      = '0;
                    r.action   = ACT_ADDR;
                    r.bus_byte = address_byte();
                end
            end
            default:
            begin
                tx_bytes[t.load_index]   = t.load_data;
                tx_written[t.load_index] = 1'b1;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Transaction builders; fields the operation ignores carry random bits
    // ------------------------------------------------------------------

    function automatic item_t random_txn();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(item_t)-1:0];
    endfunction

    function automatic item_t start_txn(input logic [6:0] addr, input logic [7:0] txc,
                                        input logic [7:0] rxc);
        item_t t;
        t            = random_txn();
        t.op         = OP_START;
        t.slave_addr = addr;
        t.tx_count   = txc;
        t.rx_count   = rxc;
        return t;
    endfunction

    function automatic item_t event_txn(input logic nack);
        item_t t;
        t      = random_txn();
        t.op   = OP_EVENT;
        t.nack = nack;
        return t;
    endfunction

    function automatic item_t error_txn(input logic arb);
        item_t t;
        t          = random_txn();
        t.op       = OP_ERROR;
        t.arb_lost = arb;
        return t;
    endfunction

    function automatic item_t load_txn(input logic [7:0] idx, input logic [7:0] data);
        item_t t;
        t            = random_txn();
        t.op         = OP_LOAD;
        t.load_index = idx;
        t.load_data  = data;
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // One transaction on the input stream. Returns at the accepting edge
    // with tvalid still high; the caller's next step either drives the
    // next transaction or lowers tvalid.
    task automatic push_txn(input item_t t, output result_t r);
        while (!steady && $urandom_range(99) < 9)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= t.op;
        s_axis_tdata  <= {7'd0, t.load_data, t.load_index, t.arb_lost, t.nack,
                          t.rx_count, t.tx_count, t.slave_addr};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_bus_action(t, r);
        pending_results.push_back(r);
        n_txns++;
    endtask

    // A data send must never read a store entry nobody wrote: load it first
    task automatic send_txn(input item_t t, output result_t r);
        if (t.op == OP_EVENT && !t.nack && pos_q < wr_len_q && !tx_written[pos_q])
            push_txn(load_txn(pos_q, 8'($urandom)), r);
        push_txn(t, r);
    endtask

    // Sender holds off until the block has returned everything
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_retry_limit(input logic [3:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        lim_q = value;
    endtask

    // ------------------------------------------------------------------
    // Output side: random back-pressure, result checking, watchdog
    // ------------------------------------------------------------------

    always @(posedge clk)
        m_axis_tready <= steady || ($urandom_range(99) >= 9);

    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got            = '0;
            got.action     = action_t'(m_axis_tuser);
            got.bus_byte   = m_axis_tdata[7:0];
            got.force_idle = m_axis_tdata[8];
            got.done_res   = m_axis_tdata[9];
            got.failed     = m_axis_tdata[10];
            if (pending_results.size() == 0)
            begin
                errors++;
                $display({"%0t: expected no result, got action %0d byte %h idle %b ",
                          "done %b fail %b"},
                         $time, got.action, got.bus_byte, got.force_idle,
                         got.done_res, got.failed);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    errors++;
                    $display({"%0t: mismatch expected action %0d byte %h idle %b done %b ",
                              "fail %b, got action %0d byte %h idle %b done %b fail %b"},
                             $time, want.action, want.bus_byte, want.force_idle,
                             want.done_res, want.failed, got.action, got.bus_byte,
                             got.force_idle, got.done_res, got.failed);
                end
            end
        end
    end

    // Any cycle with a transaction on either side resets the count
    initial
    begin
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Events on the reset state: empty write, zero address, limit 3
    task automatic test_events_before_start();
        result_t r;
        send_txn(event_txn(1'b0), r);
        send_txn(event_txn(1'b1), r);
        send_txn(error_txn(1'b1), r);
        send_txn(error_txn(1'b0), r);
    endtask

    // Two data bytes, then the repeated address for the read phase; with
    // reception absent, a further event repeats that address
    task automatic test_write_then_read();
        result_t r;
        send_txn(load_txn(8'd0, 8'h00), r);
        send_txn(load_txn(8'd1, 8'hFF), r);
        send_txn(load_txn(8'd255, 8'hA5), r);
        send_txn(start_txn(7'h7F, 8'd2, 8'd255), r);
        send_txn(event_txn(1'b0), r);
        send_txn(event_txn(1'b0), r);
        send_txn(event_txn(1'b0), r);
        send_txn(event_txn(1'b0), r);
        send_txn(event_txn(1'b1), r);
        // nothing to write or read: read bit on the address, plain success
        send_txn(start_txn(7'h00, 8'd0, 8'd0), r);
        send_txn(event_txn(1'b0), r);
    endtask

    // Limit extremes: with 0 the first NACK fails and a lost arbitration
    // past the limit does nothing; with 15 a NACK and a lost arbitration re-address
    task automatic test_retry_limit_extremes();
        result_t r;
        write_retry_limit(4'd0);
        send_txn(start_txn(7'h55, 8'd1, 8'd0), r);
        send_txn(event_txn(1'b1), r);
        send_txn(error_txn(1'b1), r);
        write_retry_limit(4'd15);
        send_txn(start_txn(7'h2A, 8'd255, 8'd7), r);
        send_txn(error_txn(1'b0), r);
        send_txn(error_txn(1'b1), r);
        send_txn(event_txn(1'b1), r);
    endtask

    // Long NACK / error storm without a new start: the retry count must
    // stick at its maximum rather than wrap and allow retries again
    task automatic test_retry_saturation();
        result_t r;
        int      i;
        send_txn(start_txn(7'($urandom), 8'd0, 8'($urandom)), r);
        for (i = 0; i < 270; i++)
        begin
            if ($urandom_range(99) < 80)
                send_txn(event_txn(1'b1), r);
            else
                send_txn(error_txn(1'($urandom)), r);
        end
    endtask

    // One well-formed transfer with random content, run until done or cut off
    task automatic run_transfer();
        result_t r;
        int      i;
        int      n_loads;
        int      pick;
        logic [7:0] txc;
        logic [7:0] rxc;
        n_loads = $urandom_range(0, 3);
        for (i = 0; i < n_loads; i++)
            send_txn(load_txn(8'($urandom), 8'($urandom)), r);
        // mostly short writes; now and then a long one
        txc = ($urandom_range(0, 24) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
        rxc = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        send_txn(start_txn(7'($urandom), txc, rxc), r);
        for (i = 0; i < int'(txc) + 24; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_txn(error_txn(1'($urandom)), r);
            else if (pick < 20)
                send_txn(event_txn(1'b1), r);
            else
                send_txn(event_txn(1'b0), r);
            if (r.done_res)
                break;
            if (r.action == ACT_STOP_ADDR && $urandom_range(1) == 0)
                break;
        end
    endtask

    // Random phases, each under its own retry limit; one phase runs with
    // both sides always ready
    task automatic test_random_transfers();
        result_t r;
        int      phase;
        int      phase_end;
        logic [3:0] limits[5];
        limits = '{4'd15, 4'd0, 4'd1, 4'd3, 4'($urandom)};
        for (phase = 0; phase < 5; phase++)
        begin
            write_retry_limit(limits[phase]);
            steady = (phase == 2);
            phase_end = n_txns + (TXN_TARGET - n_txns) / (5 - phase);
            while (n_txns < phase_end)
            begin
                if ($urandom_range(99) < 10)
                    send_txn(random_txn(), r);
                else
                    run_transfer();
            end
            steady = 1'b0;
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_events_before_start();
        test_write_then_read();
        test_retry_limit_extremes();
        test_retry_saturation();
        test_random_transfers();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
